>>> hw/rtl/clas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clas_pkg;

    localparam int MAX_BACKSLASH_RUN = 255;
    localparam int MAX_ARGS          = 255;

    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_TAB    = 16'h0009;

    // every third quote level in a quote run emits one quote
    localparam logic [1:0] QUOTE_EMIT_LEVEL = 2'd3;
    localparam logic [1:0] QUOTE_OPEN_LEVEL = 2'd2;

    typedef enum logic [2:0] {
        PH_START       = 3'd0,
        PH_PROG_QUOTED = 3'd1,
        PH_PROG_PLAIN  = 3'd2,
        PH_GAP         = 3'd3,
        PH_ARG         = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] held_backslashes;
        logic [1:0] quote_level;
        logic       in_quote_run;
        logic [7:0] current_arg;
        logic       overflow_seen;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:            PH_START,
        held_backslashes: 8'd0,
        quote_level:      2'd0,
        in_quote_run:     1'b0,
        current_arg:      8'd0,
        overflow_seen:    1'b0
    };

    typedef struct packed {
        logic [15:0] char_code;
        logic        last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  backslash_run;
        logic [15:0] out_char;
        logic [1:0]  char_copies;
        logic [7:0]  arg_number;
        logic        arg_closed;
        logic [7:0]  total_args;
        logic        run_overflow;
        logic        end_of_line;
    } t_out_item;

endpackage
`default_nettype wire

>>> hw/rtl/clas_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clas_in_if import clas_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface clas_out_if import clas_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/clas_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One character of splitting: current state and character in, next state
// and the result item out. Purely combinational.
module clas_step import clas_pkg::*; (
    input  wire t_state    i_state,
    input  wire t_in_item  i_item,
    output t_state         o_state,
    output t_out_item      o_result
);

    logic        blank;
    logic        is_quote;
    logic        is_bslash;
    logic        do_arg;
    logic        gap_start;
    logic [7:0]  a_held;
    logic [1:0]  a_level;
    logic        a_run;
    logic [1:0]  level_inc;
    logic [7:0]  bs;
    logic [15:0] ch;
    logic [1:0]  copies;
    logic        closed;
    t_state      n;

    assign blank     = (i_item.char_code == CH_SPACE) || (i_item.char_code == CH_TAB);
    assign is_quote  = (i_item.char_code == CH_QUOTE);
    assign is_bslash = (i_item.char_code == CH_BSLASH);
    assign gap_start = (i_state.phase == PH_GAP) && !blank;
    assign do_arg    = (i_state.phase == PH_ARG) || gap_start;

    // a new argument starts with cleared backslash and quote state
    assign a_held    = gap_start ? 8'd0 : i_state.held_backslashes;
    assign a_level   = gap_start ? 2'd0 : i_state.quote_level;
    assign a_run     = gap_start ? 1'b0 : i_state.in_quote_run;
    assign level_inc = a_level + 2'd1;

    always_comb begin
        n      = i_state;
        bs     = 8'd0;
        ch     = 16'd0;
        copies = 2'd0;
        closed = 1'b0;

        unique case (i_state.phase)
            PH_PROG_QUOTED: begin
                if (is_quote) begin
                    closed  = 1'b1;
                    n.phase = PH_GAP;
                end else begin
                    ch     = i_item.char_code;
                    copies = 2'd1;
                end
            end
            PH_PROG_PLAIN: begin
                if (blank) begin
                    closed  = 1'b1;
                    n.phase = PH_GAP;
                end else begin
                    ch     = i_item.char_code;
                    copies = 2'd1;
                end
            end
            PH_GAP: begin
                if (!blank) begin
                    if (i_state.current_arg < 8'(MAX_ARGS - 1)) begin
                        n.current_arg = i_state.current_arg + 8'd1;
                    end
                    n.phase = PH_ARG;
                end
            end
            PH_ARG: begin
            end
            default: begin
                if (is_quote) begin
                    n.phase = PH_PROG_QUOTED;
                end else if (blank) begin
                    closed  = 1'b1;
                    n.phase = PH_GAP;
                end else begin
                    ch      = i_item.char_code;
                    copies  = 2'd1;
                    n.phase = PH_PROG_PLAIN;
                end
            end
        endcase

        if (do_arg) begin
            n.held_backslashes = a_held;
            n.quote_level      = a_level;
            n.in_quote_run     = a_run;
            if (is_quote) begin
                if (a_run) begin
                    if (level_inc == QUOTE_EMIT_LEVEL) begin
                        ch            = CH_QUOTE;
                        copies        = 2'd1;
                        n.quote_level = 2'd0;
                    end else begin
                        n.quote_level = level_inc;
                    end
                end else begin
                    // half the held run goes out, odd count doubles the quote
                    bs = {1'b0, a_held[7:1]};
                    ch = CH_QUOTE;
                    if (a_held[0]) begin
                        copies = 2'd2;
                    end else begin
                        copies        = 2'd1;
                        n.quote_level = level_inc;
                    end
                    n.held_backslashes = 8'd0;
                    n.in_quote_run     = 1'b1;
                end
            end else begin
                n.in_quote_run = 1'b0;
                if (a_run && (a_level == QUOTE_OPEN_LEVEL)) begin
                    n.quote_level = 2'd0;
                end
                if (is_bslash) begin
                    if (a_held < 8'(MAX_BACKSLASH_RUN)) begin
                        n.held_backslashes = a_held + 8'd1;
                    end else begin
                        n.overflow_seen = 1'b1;
                    end
                end else begin
                    bs                 = a_held;
                    n.held_backslashes = 8'd0;
                    if (blank && (n.quote_level == 2'd0)) begin
                        closed  = 1'b1;
                        n.phase = PH_GAP;
                    end else begin
                        ch     = i_item.char_code;
                        copies = 2'd1;
                    end
                end
            end
        end

        // end of line closes an open argument and flushes held backslashes
        if (i_item.last_char && !closed &&
            ((n.phase == PH_PROG_QUOTED) || (n.phase == PH_PROG_PLAIN) ||
             (n.phase == PH_ARG))) begin
            closed = 1'b1;
            if (n.phase == PH_ARG) begin
                bs = bs + n.held_backslashes;
            end
        end

        o_result.backslash_run = bs;
        o_result.out_char      = ch;
        o_result.char_copies   = copies;
        o_result.arg_number    = n.current_arg;
        o_result.arg_closed    = closed;
        o_result.total_args    = i_item.last_char ? (n.current_arg + 8'd1) : 8'd0;
        o_result.run_overflow  = n.overflow_seen;
        o_result.end_of_line   = i_item.last_char;

        o_state = i_item.last_char ? STATE_RESET : n;
    end

endmodule
`default_nettype wire

>>> hw/rtl/command_line_argument_splitter_top.sv
// Pipeline: a request passes the input register and then the result register before its result is valid.
// Throughput: one character per cycle while the result side does not stall; each character gives exactly one result.
// Backpressure on the result side stalls the input register only when both stages are full.
// Reset: synchronous, active low; clears valids and returns the splitter to start of line.
`timescale 1ns / 1ps
`default_nettype none

module command_line_argument_splitter_top import clas_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    clas_in_if.sink           i_in,
    clas_out_if.source        o_out
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_state    r_state;

    t_state    n_state;
    t_out_item n_out;
    logic      move;

    clas_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign move        = r_in_valid && (!r_out_valid || o_out.ready);
    // no request is taken while reset is held
    assign i_in.ready  = i_rst_n && (!r_in_valid || move);
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    a_line_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in.last_char) |=> (r_state.phase == PH_START) &&
                                     (r_state.current_arg == 8'd0) &&
                                     !r_state.overflow_seen)
        else $error("state not cleared after end of line");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_START) |->
            (r_state.current_arg == 8'd0) && (r_state.held_backslashes == 8'd0))
        else $error("start of line with stale argument state");

    a_total_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.end_of_line) |-> (r_out.total_args == 8'd0))
        else $error("argument count outside end of line");

    a_no_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.char_copies == 2'd0)) |-> (r_out.out_char == 16'd0))
        else $error("character present with no copies");

endmodule
`default_nettype wire
